FILE: sv/ardm_pkg.sv
// ----------------------------------------------------------------------------
// ardm_pkg
// Shared types and constants of the address region decoder memory: the item
// structs, the configuration register map and the controller command set.
// ----------------------------------------------------------------------------
package ardm_pkg;

    // Address space and configuration layout.
    localparam int ADDR_W        = 20;
    localparam int DATA_W        = 16;
    localparam int CFG_SLOTS     = 4;
    localparam int COUNT_W       = 3;
    localparam int PADDR_W       = 6;
    localparam int PDATA_W       = 64;
    localparam int REG_IDX_W     = 3;

    // Defaults for the top-level parameters.
    localparam int NUM_REGIONS_DEF  = 4;
    localparam int REGION_BYTES_DEF = 4096;

    // Reset value of the unmapped-read byte.
    localparam logic [7:0] DEFAULT_BYTE_RST = 8'haa;

    // Access codes.
    localparam logic [1:0] FUNC_RD_BYTE = 2'd0;
    localparam logic [1:0] FUNC_RD_WORD = 2'd1;
    localparam logic [1:0] FUNC_WR_BYTE = 2'd2;
    localparam logic [1:0] FUNC_WR_WORD = 2'd3;

    // Register indexes; register i sits at byte address 8*i.
    localparam logic [REG_IDX_W-1:0] REG_COUNT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REGION0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REGION3 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT = 3'd5;

    // One region descriptor, laid out as the register bits.
    typedef struct packed {
        logic              read_only;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] base;
    } t_region;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [COUNT_W-1:0]          region_count;
        t_region [CFG_SLOTS-1:0]     regions;
        logic [7:0]                  default_byte;
    } t_ardm_cfg;

    // Input item.
    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              mapped;
        logic              write_dropped;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic decode;
        logic mul;
        logic reduce;
        logic acc_lo;
        logic acc_hi;
        logic load_out;
    } t_ardm_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic word_access;
    } t_ardm_stat;

endpackage

FILE: sv/ardm_cfg.sv
// ----------------------------------------------------------------------------
// ardm_cfg
// Configuration register file behind an APB-style port: region count, four
// region descriptors and the default byte. Registers are 8 bytes apart.
// ----------------------------------------------------------------------------
module ardm_cfg
    import ardm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_ardm_cfg          o_cfg
);

    logic [COUNT_W-1:0]      r_count;
    t_region [CFG_SLOTS-1:0] r_regions;
    logic [7:0]              r_default;

    logic [REG_IDX_W-1:0]    reg_idx;
    logic [1:0]              slot;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign slot    = 2'(reg_idx - REG_REGION0);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_regions <= '0;
            r_default <= DEFAULT_BYTE_RST;
        end else if (wr_en) begin
            unique case (reg_idx) inside
                REG_COUNT: begin
                    r_count <= pwdata[COUNT_W-1:0];
                end
                [REG_REGION0:REG_REGION3]: begin
                    r_regions[slot] <= pwdata[$bits(t_region)-1:0];
                end
                REG_DEFAULT: begin
                    r_default <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        prdata = '0;
        unique case (reg_idx) inside
            REG_COUNT:                 prdata = PDATA_W'(r_count);
            [REG_REGION0:REG_REGION3]: prdata = PDATA_W'(r_regions[slot]);
            REG_DEFAULT:               prdata = PDATA_W'(r_default);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.region_count = r_count;
    assign o_cfg.regions      = r_regions;
    assign o_cfg.default_byte = r_default;

endmodule

FILE: sv/ardm_ctrl.sv
// ----------------------------------------------------------------------------
// ardm_ctrl
// Sequencer of one access: decode, offset reduction, low byte access, high
// byte access for word items, and hand-off into the output register.
// ----------------------------------------------------------------------------
module ardm_ctrl
    import ardm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_ardm_stat i_stat,
    output t_ardm_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_RED,
        S_LO,
        S_HI,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and output-valid tracking.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: n_state = S_MUL;
            S_MUL:    n_state = S_RED;
            S_RED:    n_state = S_LO;
            S_LO:     n_state = i_stat.word_access ? S_HI : S_FIN;
            S_HI:     n_state = S_FIN;
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Commands decoded from the state.
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.decode    = (r_state == S_DECODE);
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.reduce    = (r_state == S_RED);
    assign o_cmd.acc_lo    = (r_state == S_LO);
    assign o_cmd.acc_hi    = (r_state == S_HI);
    assign o_cmd.load_out  = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

endmodule

FILE: sv/ardm_dp.sv
// ----------------------------------------------------------------------------
// ardm_dp
// Datapath: item register, per-region window decode, offset reduction modulo
// the bank size, one byte bank per region and the output register.
// ----------------------------------------------------------------------------
module ardm_dp
    import ardm_pkg::*;
#(
    parameter int NUM_REGIONS  = NUM_REGIONS_DEF,
    parameter int REGION_BYTES = REGION_BYTES_DEF
) (
    input  logic       i_clk,
    input  t_ardm_cfg  i_cfg,
    input  t_in_item   i_in_data,
    input  t_ardm_cmd  i_cmd,
    output t_ardm_stat o_stat,
    output t_out_item  o_out_data
);

    // Only regions with a configuration slot can ever match.
    localparam int NB   = (NUM_REGIONS < CFG_SLOTS) ? NUM_REGIONS : CFG_SLOTS;
    localparam int AW   = $clog2(REGION_BYTES);
    localparam int RW   = AW + 1;
    localparam int SH   = ADDR_W + AW;
    localparam int MW   = ADDR_W + 2;
    localparam int QW   = ADDR_W - AW + 1;
    localparam int PW   = ADDR_W + MW;
    localparam longint unsigned RECIP = (64'd1 << SH) / REGION_BYTES;
    localparam logic [MW-1:0]     RECIP_V = MW'(RECIP);
    localparam logic [ADDR_W-1:0] RB_A    = ADDR_W'(REGION_BYTES);
    localparam logic [RW-1:0]     RB_R    = RW'(REGION_BYTES);
    localparam logic [AW-1:0]     RB_LAST = AW'(REGION_BYTES - 1);

    t_in_item             r_item;
    logic [NB-1:0]        r_hit;
    logic [NB-1:0]        r_at_last;
    logic [ADDR_W-1:0]    r_diff [NB];
    logic [QW-1:0]        r_q    [NB];
    logic [RW-1:0]        r_raw  [NB];
    logic [AW-1:0]        r_off  [NB];
    logic [7:0]           r_rd   [NB];
    logic [7:0]           r_lo_data;
    t_out_item            r_out;

    logic [COUNT_W-1:0]   n_act;
    logic                 is_read;
    logic                 is_word;
    logic [NB-1:0]        first_oh;
    logic [NB-1:0]        wr_lane;
    logic                 any_hit;
    logic                 any_ro;
    logic [7:0]           sel_rd;
    logic                 sel_at_last;
    logic                 mem_en;

    assign is_read = (r_item.func == FUNC_RD_BYTE) || (r_item.func == FUNC_RD_WORD);
    assign is_word = (r_item.func == FUNC_RD_WORD) || (r_item.func == FUNC_WR_WORD);
    assign mem_en  = i_cmd.acc_lo || i_cmd.acc_hi;
    assign n_act   = (i_cfg.region_count > COUNT_W'(NB)) ? COUNT_W'(NB)
                                                          : i_cfg.region_count;

    assign o_stat.word_access = is_word;

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
    end

    // Priority pick of the first hit, and the lanes a write reaches: every
    // hit before the first read-only hit.
    always_comb begin
        logic seen;
        logic blocked;
        seen     = 1'b0;
        blocked  = 1'b0;
        any_ro   = 1'b0;
        first_oh = '0;
        wr_lane  = '0;
        for (int r = 0; r < NB; r++) begin
            first_oh[r] = r_hit[r] && !seen;
            seen        = seen || r_hit[r];
            blocked     = blocked || (r_hit[r] && i_cfg.regions[r].read_only);
            wr_lane[r]  = r_hit[r] && !blocked;
        end
        any_ro  = blocked;
        any_hit = seen;
    end

    // Data of the first matching lane.
    always_comb begin
        sel_rd      = '0;
        sel_at_last = 1'b0;
        for (int r = 0; r < NB; r++) begin
            if (first_oh[r]) begin
                sel_rd      = r_rd[r];
                sel_at_last = r_at_last[r];
            end
        end
    end

    for (genvar r = 0; r < NB; r++) begin : g_lane
        logic [PW-1:0]     prod;
        logic [ADDR_W-1:0] qc;
        logic [ADDR_W-1:0] raw_full;
        logic [AW-1:0]     off_lo;
        logic [AW-1:0]     off_hi;
        logic [AW-1:0]     mem_addr;
        logic [7:0]        mem_wdata;
        logic              mem_we;
        logic [7:0]        mem [REGION_BYTES];

        assign prod     = PW'(r_diff[r]) * PW'(RECIP_V);
        assign qc       = ADDR_W'(r_q[r]) * RB_A;
        assign raw_full = r_diff[r] - qc;
        assign off_lo   = (r_raw[r] >= RB_R) ? AW'(r_raw[r] - RB_R) : r_raw[r][AW-1:0];
        assign off_hi   = (r_off[r] == RB_LAST) ? '0 : r_off[r] + AW'(1);
        assign mem_addr = i_cmd.acc_hi ? off_hi : off_lo;
        assign mem_wdata = i_cmd.acc_hi ? r_item.write_data[15:8]
                                        : r_item.write_data[7:0];
        assign mem_we   = !is_read && wr_lane[r]
                       && (i_cmd.acc_lo || (i_cmd.acc_hi && !r_at_last[r]));

        // Window decode, then the quotient estimate, then the remainder.
        always_ff @(posedge i_clk) begin
            if (i_cmd.decode) begin
                r_hit[r]     <= (COUNT_W'(r) < n_act)
                             && (r_item.address >= i_cfg.regions[r].base)
                             && (r_item.address <= i_cfg.regions[r].last);
                r_at_last[r] <= (r_item.address == i_cfg.regions[r].last);
                r_diff[r]    <= r_item.address - i_cfg.regions[r].base;
            end
            if (i_cmd.mul) begin
                r_q[r] <= prod[SH +: QW];
            end
            if (i_cmd.reduce) begin
                r_raw[r] <= raw_full[RW-1:0];
            end
            if (i_cmd.acc_lo) begin
                r_off[r] <= off_lo;
            end
        end

        // Byte bank of this region.
        always_ff @(posedge i_clk) begin
            if (mem_we) begin
                mem[mem_addr] <= mem_wdata;
            end
            if (mem_en) begin
                r_rd[r] <= mem[mem_addr];
            end
        end
    end

    // Low byte of a word read is kept while the high byte is fetched.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_hi) begin
            r_lo_data <= sel_rd;
        end
    end

    // Result assembly into the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.mapped        <= any_hit;
            r_out.write_dropped <= !is_read && any_ro;
            if (!is_read) begin
                r_out.read_data <= '0;
            end else if (!any_hit) begin
                r_out.read_data <= is_word ? {i_cfg.default_byte, i_cfg.default_byte}
                                           : {8'h00, i_cfg.default_byte};
            end else if (!is_word) begin
                r_out.read_data <= {8'h00, sel_rd};
            end else if (sel_at_last) begin
                r_out.read_data <= {i_cfg.default_byte, r_lo_data};
            end else begin
                r_out.read_data <= {sel_rd, r_lo_data};
            end
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: sv/address_region_decoder_memory.sv
// ----------------------------------------------------------------------------
// address_region_decoder_memory
// Byte and word accesses decoded over up to four address regions, each with
// its own single-port byte bank. An access runs through decode, quotient,
// remainder, low byte, high byte (word accesses only) and output steps. A new
// item is taken only once the shared sequencer is back in idle, so items do
// not overlap; the output step waits while the previous result is not taken.
// Reset clears the control state and the configuration registers; bank
// contents are undefined until written, and items are taken right after reset.
// ----------------------------------------------------------------------------
module address_region_decoder_memory
    import ardm_pkg::*;
#(
    parameter int NUM_REGIONS  = NUM_REGIONS_DEF,
    parameter int REGION_BYTES = REGION_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_ardm_cfg  cfg;
    t_ardm_cmd  cmd;
    t_ardm_stat stat;

    // Configuration registers.
    ardm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Access sequencer.
    ardm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Decode, offset and bank datapath.
    ardm_dp #(
        .NUM_REGIONS  (NUM_REGIONS),
        .REGION_BYTES (REGION_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule
